/* hw/rtl/collar_command_zone_tracker_defines.svh */
// Assertion macros shared by the tracker RTL.
`ifndef COLLAR_COMMAND_ZONE_TRACKER_DEFINES_SVH
`define COLLAR_COMMAND_ZONE_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define CCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset
`define CCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define CCT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/cct_pkg.sv */
`timescale 1ns / 1ps

package cct_pkg;

    // Packet characters
    localparam logic [7:0] CH_ZONE     = 8'h7A; // 'z'
    localparam logic [7:0] CH_SET      = 8'h73; // 's'
    localparam logic [7:0] CH_TONE     = 8'h6D; // 'm'
    localparam logic [7:0] CH_BOUND    = 8'h62; // 'b'
    localparam logic [7:0] CH_HOME     = 8'h68; // 'h'
    localparam logic [7:0] CH_PRIMARY  = 8'h70; // 'p'
    localparam logic [7:0] CH_SECOND   = 8'h73; // 's'
    localparam logic [7:0] CH_ON       = 8'h6E; // 'n'
    localparam logic [7:0] CH_DIGIT_1  = 8'h31; // '1'
    localparam logic [7:0] CH_DIGIT_4  = 8'h34; // '4'
    localparam logic [7:0] CH_DIGIT_5  = 8'h35; // '5'

    // Tone codes
    localparam logic [2:0] TONE_NONE     = 3'd0;
    localparam logic [2:0] TONE_HI_SHORT = 3'd1;
    localparam logic [2:0] TONE_LO_SHORT = 3'd2;
    localparam logic [2:0] TONE_HI_LONG  = 3'd3;
    localparam logic [2:0] TONE_LO_LONG  = 3'd4;

    // Pairing states
    localparam logic [1:0] PAIR_NONE      = 2'd0;
    localparam logic [1:0] PAIR_PRIMARY   = 2'd1;
    localparam logic [1:0] PAIR_SECONDARY = 2'd2;

    localparam logic [2:0] ZONE_MAX = 3'd5;

    // Classified command
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ZONE,
        CMD_CLOSE,
        CMD_SET,
        CMD_TONE,
        CMD_BOUND,
        CMD_HOME
    } t_cmd;

    // Item passed from the front to the back through the queue
    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] zone;     // zone for CMD_ZONE, limit for CMD_SET
        logic       arg_on;
        logic       tgt_p;
        logic       tgt_s;
        logic       count0;
        logic       count1;
        logic [7:0] addr;
    } t_cmd_item;

    // Queue control from the front: push strobe and the full flag it saw
    typedef struct packed {
        logic push;
        logic full;
    } t_q_ctrl;

endpackage

/* hw/rtl/cct_channels.sv */
`timescale 1ns / 1ps

// Packet input channel
interface cct_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_kind;
    logic [7:0] target_byte;
    logic [7:0] argument_byte;
    logic [7:0] paired_count;
    logic [7:0] sender_address;

    modport source (
        output valid, packet_kind, target_byte, argument_byte, paired_count,
               sender_address,
        input  ready
    );
    modport sink (
        input  valid, packet_kind, target_byte, argument_byte, paired_count,
               sender_address,
        output ready
    );
endinterface

// Result output channel
interface cct_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] first_tone;
    logic [2:0] second_tone;
    logic       report_valid;
    logic       report_role;
    logic [2:0] report_zone;
    logic [1:0] pairing_role;
    logic       boundary_enabled;
    logic       homing_enabled;
    logic [2:0] allowed_zone;
    logic [7:0] paired_address;

    modport source (
        output valid, first_tone, second_tone, report_valid, report_role, report_zone,
               pairing_role, boundary_enabled, homing_enabled, allowed_zone,
               paired_address,
        input  ready
    );
    modport sink (
        input  valid, first_tone, second_tone, report_valid, report_role, report_zone,
               pairing_role, boundary_enabled, homing_enabled, allowed_zone,
               paired_address,
        output ready
    );
endinterface

/* hw/rtl/cct_front.sv */
`timescale 1ns / 1ps

// Accepts packets and decodes them into commands for the queue.
module cct_front (
    cct_pkt_if.sink           i_pkt,
    input  logic              i_q_full,
    output cct_pkg::t_q_ctrl  o_q_ctrl,
    output cct_pkg::t_cmd_item o_item
);

    logic [7:0] w_arg;
    logic       w_digit_14;

    assign w_arg      = i_pkt.argument_byte;
    assign w_digit_14 = (w_arg >= cct_pkg::CH_DIGIT_1) && (w_arg <= cct_pkg::CH_DIGIT_4);

    // Handshake: take a packet whenever the queue has room
    assign i_pkt.ready     = !i_q_full;
    assign o_q_ctrl.push   = i_pkt.valid && !i_q_full;
    assign o_q_ctrl.full   = i_q_full;

    // Classification
    always_comb begin
        o_item.cmd    = cct_pkg::CMD_NONE;
        o_item.zone   = 3'd0;
        o_item.arg_on = (w_arg == cct_pkg::CH_ON);
        o_item.tgt_p  = (i_pkt.target_byte == cct_pkg::CH_PRIMARY);
        o_item.tgt_s  = (i_pkt.target_byte == cct_pkg::CH_SECOND);
        o_item.count0 = (i_pkt.paired_count == 8'd0);
        o_item.count1 = (i_pkt.paired_count == 8'd1);
        o_item.addr   = i_pkt.sender_address;
        case (i_pkt.packet_kind)
            cct_pkg::CH_ZONE: begin
                if (w_digit_14) begin
                    // zone = 5 - digit = '5' - char
                    o_item.cmd  = cct_pkg::CMD_ZONE;
                    o_item.zone = 3'(cct_pkg::CH_DIGIT_5 - w_arg);
                end else if (w_arg == cct_pkg::CH_DIGIT_5) begin
                    o_item.cmd = cct_pkg::CMD_CLOSE;
                end
            end
            cct_pkg::CH_SET: begin
                if (w_digit_14) begin
                    o_item.cmd  = cct_pkg::CMD_SET;
                    o_item.zone = 3'(w_arg - (cct_pkg::CH_DIGIT_1 - 8'd1));
                end
            end
            cct_pkg::CH_TONE:  o_item.cmd = cct_pkg::CMD_TONE;
            cct_pkg::CH_BOUND: o_item.cmd = cct_pkg::CMD_BOUND;
            cct_pkg::CH_HOME:  o_item.cmd = cct_pkg::CMD_HOME;
            default:           o_item.cmd = cct_pkg::CMD_NONE;
        endcase
    end

endmodule

/* hw/rtl/cct_queue.sv */
`timescale 1ns / 1ps

`include "collar_command_zone_tracker_defines.svh"

// Two-entry command queue between front and back.
module cct_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cct_pkg::t_q_ctrl   i_q_ctrl,
    input  cct_pkg::t_cmd_item i_item,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output cct_pkg::t_cmd_item o_item
);

    localparam int Depth = 2;

    cct_pkg::t_cmd_item r_mem [Depth];
    logic               r_wr_ptr, n_wr_ptr;
    logic               r_rd_ptr, n_rd_ptr;
    logic [1:0]         r_count, n_count;
    logic               w_push, w_pop;

    assign w_push  = i_q_ctrl.push;
    assign w_pop   = i_pop && (r_count != 2'd0);
    assign o_full  = (r_count == 2'(Depth));
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = w_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `CCT_ASSERT_IMPL(a_q_count_bound, i_clk, i_rst_n, 1'b1, r_count <= 2'(Depth))
    `CCT_ASSERT_IMPL(a_q_no_overflow, i_clk, i_rst_n, w_push, r_count != 2'(Depth))
    `CCT_ASSERT_NEXT(a_q_push_seen, i_clk, i_rst_n, w_push && !w_pop, r_count != 2'd0)
    `CCT_ASSERT_IMPL(a_q_full_view, i_clk, i_rst_n, 1'b1, i_q_ctrl.full == o_full)

endmodule

/* hw/rtl/cct_back.sv */
`timescale 1ns / 1ps

`include "collar_command_zone_tracker_defines.svh"

// Executes commands against the collar state and registers one result per item.
module cct_back #(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  cct_pkg::t_cmd_item i_item,
    output logic               o_pop,
    cct_res_if.source          o_res
);

    // Collar state
    logic [2:0] r_round_zone, n_round_zone;
    logic [2:0] r_hist [HISTORY_DEPTH];
    logic [2:0] n_hist [HISTORY_DEPTH];
    logic [2:0] r_limit, n_limit;
    logic       r_bound, n_bound;
    logic       r_home, n_home;
    logic [1:0] r_pair, n_pair;
    logic [7:0] r_ctrl_id, n_ctrl_id;

    // Output register
    logic       r_out_valid;
    logic [2:0] r_tone1, n_tone1;
    logic [2:0] r_tone2, n_tone2;
    logic       r_rep_valid, n_rep_valid;
    logic       r_rep_role, n_rep_role;
    logic [2:0] r_rep_zone, n_rep_zone;

    logic       w_addressed;
    logic       w_hist_above;
    logic [4:0] w_present;
    logic [2:0] w_min_zone;
    logic       w_outside;
    logic [2:0] w_pair_tone;

    // Take a command when the output register is empty or being drained
    assign o_pop = i_q_valid && (!r_out_valid || o_res.ready);

    assign w_addressed = ((r_pair == cct_pkg::PAIR_PRIMARY) && i_item.tgt_p) ||
                         ((r_pair == cct_pkg::PAIR_SECONDARY) && i_item.tgt_s);

    // History scan: all-above-limit flag and set of present zone values
    always_comb begin
        w_hist_above = 1'b1;
        w_present    = 5'd0;
        for (int v = 1; v <= 5; v++) begin
            if (r_round_zone == 3'(v)) w_present[v-1] = 1'b1;
        end
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (r_hist[i] <= r_limit) w_hist_above = 1'b0;
            for (int v = 1; v <= 5; v++) begin
                if (r_hist[i] == 3'(v)) w_present[v-1] = 1'b1;
            end
        end
    end

    // Lowest present zone, capped at 5
    always_comb begin
        w_min_zone = cct_pkg::ZONE_MAX;
        for (int v = 4; v >= 1; v--) begin
            if (w_present[v-1]) w_min_zone = 3'(v);
        end
    end

    assign w_outside = r_bound && (r_round_zone > r_limit) && w_hist_above;

    // Command execution
    always_comb begin
        n_round_zone = r_round_zone;
        n_hist       = r_hist;
        n_limit      = r_limit;
        n_bound      = r_bound;
        n_home       = r_home;
        n_pair       = r_pair;
        n_ctrl_id    = r_ctrl_id;
        n_tone1      = cct_pkg::TONE_NONE;
        n_tone2      = cct_pkg::TONE_NONE;
        n_rep_valid  = 1'b0;
        n_rep_role   = 1'b0;
        n_rep_zone   = 3'd0;
        w_pair_tone  = cct_pkg::TONE_NONE;
        case (i_item.cmd)
            cct_pkg::CMD_ZONE: n_round_zone = i_item.zone;
            cct_pkg::CMD_CLOSE: begin
                if (r_pair == cct_pkg::PAIR_NONE) begin
                    if (i_item.count0) begin
                        n_pair      = cct_pkg::PAIR_PRIMARY;
                        n_ctrl_id   = i_item.addr;
                        w_pair_tone = cct_pkg::TONE_LO_SHORT;
                    end else if (i_item.count1) begin
                        n_pair      = cct_pkg::PAIR_SECONDARY;
                        n_ctrl_id   = i_item.addr;
                        w_pair_tone = cct_pkg::TONE_HI_SHORT;
                    end
                end
                if (w_outside) begin
                    n_tone1 = cct_pkg::TONE_HI_SHORT;
                    n_tone2 = w_pair_tone;
                end else begin
                    n_tone1 = w_pair_tone;
                end
                n_rep_zone  = w_min_zone;
                n_rep_valid = (n_pair != cct_pkg::PAIR_NONE);
                n_rep_role  = (n_pair == cct_pkg::PAIR_SECONDARY);
                for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                    n_hist[i] = r_hist[i-1];
                end
                n_hist[0]    = r_round_zone;
                n_round_zone = cct_pkg::ZONE_MAX;
            end
            cct_pkg::CMD_SET: begin
                if (w_addressed) n_limit = i_item.zone;
            end
            cct_pkg::CMD_TONE: begin
                if (w_addressed) n_tone1 = cct_pkg::TONE_HI_LONG;
            end
            cct_pkg::CMD_BOUND: begin
                if (w_addressed) begin
                    n_bound = i_item.arg_on;
                    n_tone1 = i_item.arg_on ? cct_pkg::TONE_HI_LONG : cct_pkg::TONE_LO_LONG;
                end
            end
            cct_pkg::CMD_HOME: begin
                if (w_addressed) begin
                    n_home  = i_item.arg_on;
                    n_tone1 = i_item.arg_on ? cct_pkg::TONE_HI_LONG : cct_pkg::TONE_LO_LONG;
                end
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_zone <= cct_pkg::ZONE_MAX;
            for (int i = 0; i < HISTORY_DEPTH; i++) r_hist[i] <= 3'd1;
            r_limit      <= 3'd1;
            r_bound      <= 1'b0;
            r_home       <= 1'b0;
            r_pair       <= cct_pkg::PAIR_NONE;
            r_ctrl_id    <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_round_zone <= n_round_zone;
                r_hist       <= n_hist;
                r_limit      <= n_limit;
                r_bound      <= n_bound;
                r_home       <= n_home;
                r_pair       <= n_pair;
                r_ctrl_id    <= n_ctrl_id;
                r_out_valid  <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tone1     <= n_tone1;
            r_tone2     <= n_tone2;
            r_rep_valid <= n_rep_valid;
            r_rep_role  <= n_rep_role;
            r_rep_zone  <= n_rep_zone;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.first_tone       = r_tone1;
    assign o_res.second_tone      = r_tone2;
    assign o_res.report_valid     = r_rep_valid;
    assign o_res.report_role      = r_rep_role;
    assign o_res.report_zone      = r_rep_zone;
    assign o_res.pairing_role     = r_pair;
    assign o_res.boundary_enabled = r_bound;
    assign o_res.homing_enabled   = r_home;
    assign o_res.allowed_zone     = r_limit;
    assign o_res.paired_address   = r_ctrl_id;

    `CCT_ASSERT_IMPL(a_report_needs_pair, i_clk, i_rst_n, r_out_valid && r_rep_valid,
        r_pair != cct_pkg::PAIR_NONE)
    `CCT_ASSERT_IMPL(a_second_after_corr, i_clk, i_rst_n,
        r_out_valid && (r_tone2 != cct_pkg::TONE_NONE), r_tone1 == cct_pkg::TONE_HI_SHORT)
    `CCT_ASSERT_IMPL(a_limit_range, i_clk, i_rst_n, 1'b1,
        (r_limit >= 3'd1) && (r_limit <= 3'd4))
    `CCT_ASSERT_NEXT(a_pair_sticky, i_clk, i_rst_n, r_pair != cct_pkg::PAIR_NONE,
        r_pair == $past(r_pair))

endmodule

/* hw/rtl/collar_command_zone_tracker.sv */
// Path: an accepted packet is written into the command queue, then executed by
// the back, whose output register holds the result until it is taken.
// Throughput: one packet per cycle while results are taken; the two-entry command
// queue and the output register let the input side keep accepting while a result
// waits, until the queue fills. Reset: synchronous, active low; restores the zone,
// history, limit, flags, pairing and controller address to their power-up values.
`timescale 1ns / 1ps

module collar_command_zone_tracker #(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cct_pkt_if.sink    i_pkt,
    cct_res_if.source  o_res
);

    cct_pkg::t_q_ctrl   w_q_ctrl;
    cct_pkg::t_cmd_item w_front_item;
    cct_pkg::t_cmd_item w_back_item;
    logic               w_q_full;
    logic               w_q_valid;
    logic               w_pop;

    // Front: packet intake and decode
    cct_front u_front (
        .i_pkt    (i_pkt),
        .i_q_full (w_q_full),
        .o_q_ctrl (w_q_ctrl),
        .o_item   (w_front_item)
    );

    // Command queue
    cct_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_ctrl (w_q_ctrl),
        .i_item   (w_front_item),
        .o_full   (w_q_full),
        .o_valid  (w_q_valid),
        .i_pop    (w_pop),
        .o_item   (w_back_item)
    );

    // Back: state update and result register
    cct_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_item    (w_back_item),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule
